@@ hw/rtl/iprcs_pkg.sv @@
// ----------------------------------------------------------------------------
// iprcs_pkg
// Shared types and constants of the ingress round-robin cell segmenter.
// ----------------------------------------------------------------------------
package iprcs_pkg;

    localparam int NUM_PORTS_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [10:0] CELL_LENGTH_RST = 11'd64;
    localparam logic [10:0] MIN_CELL        = 11'd32;

    localparam logic REQ_ARRIVAL  = 1'b0;
    localparam logic REQ_SCHEDULE = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_DROP   = 2'd1,
        KIND_CELL   = 2'd2,
        KIND_IDLE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CELL
    } state_t;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  port;
        logic [7:0]  src_id;
        logic [7:0]  dst_id;
        logic [2:0]  priority_req;
        logic [10:0] pkt_len;
    } req_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  out_port;
        logic [7:0]  out_src;
        logic [7:0]  out_dst;
        logic [2:0]  out_priority;
        logic [8:0]  queue_id;
        logic [9:0]  flow_id;
        logic [10:0] cell_bytes;
        logic [5:0]  cell_seq;
        logic        last;
        logic [31:0] rx_total;
        logic [31:0] drop_total;
    } res_t;

    // packet header as held in the queue store
    typedef struct packed {
        logic [10:0] len;
        logic [2:0]  prio;
        logic [7:0]  dst;
        logic [7:0]  src;
    } hdr_t;

    typedef struct packed {
        logic load;
        logic adv;
    } seg_ctrl_t;

endpackage

@@ hw/rtl/iprcs_seg.sv @@
// ----------------------------------------------------------------------------
// iprcs_seg
// Splits one popped packet header into cells, one cell per advance.
// ----------------------------------------------------------------------------
module iprcs_seg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iprcs_pkg::seg_ctrl_t ctrl,
    input  iprcs_pkg::hdr_t      hdr,
    input  logic [1:0]           port,
    input  logic [10:0]          cell_size,
    output logic                 active,
    output iprcs_pkg::res_t      cell_out
);

    logic            active_reg;
    iprcs_pkg::hdr_t hdr_reg;
    logic [1:0]      port_reg;
    logic [10:0]     cl_reg;
    logic [10:0]     rem_reg;
    logic [5:0]      seq_reg;
    logic [10:0]     cl_clamped;
    logic            cell_last;
    logic [8:0]      qid;

    assign cl_clamped = (cell_size < iprcs_pkg::MIN_CELL) ? iprcs_pkg::MIN_CELL : cell_size;
    assign cell_last  = (rem_reg <= cl_reg);
    assign qid        = {1'b0, hdr_reg.src} + {1'b0, hdr_reg.dst};
    assign active     = active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            active_reg <= 1'b1;
        end
        else if (ctrl.adv && cell_last)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            hdr_reg  <= hdr;
            port_reg <= port;
            cl_reg   <= cl_clamped;
            rem_reg  <= hdr.len;
            seq_reg  <= '0;
        end
        else if (ctrl.adv && !cell_last)
        begin
            rem_reg <= rem_reg - cl_reg;
            seq_reg <= seq_reg + 6'd1;
        end
    end

    always_comb
    begin
        cell_out              = '0;
        cell_out.kind         = iprcs_pkg::KIND_CELL;
        cell_out.out_port     = port_reg;
        cell_out.out_src      = hdr_reg.src;
        cell_out.out_dst      = hdr_reg.dst;
        cell_out.out_priority = hdr_reg.prio;
        cell_out.queue_id     = qid;
        cell_out.flow_id      = {qid, 1'b0};
        cell_out.cell_bytes   = cell_last ? rem_reg : cl_reg;
        cell_out.cell_seq     = seq_reg;
        cell_out.last         = cell_last;
    end

endmodule

@@ hw/rtl/ingress_port_rr_cell_segmenter_unit.sv @@
// ----------------------------------------------------------------------------
// ingress_port_rr_cell_segmenter_unit
// Arrival request: result in the output register on the next edge; arrivals
// sustain one per cycle while the result register is free to take them.
// Schedule request: queue store read, then segmenter load, then one cell per
// cycle while the result side does not stall; busy until the last cell leaves.
// Reset clears queue pointers, fill levels and counters and sets the round robin
// pointer to the last port; the queue store itself needs no clearing.
// ----------------------------------------------------------------------------
module ingress_port_rr_cell_segmenter_unit #(
    parameter int NUM_PORTS   = iprcs_pkg::NUM_PORTS_DEF,
    parameter int QUEUE_DEPTH = iprcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  iprcs_pkg::req_t req_data,
    output logic            res_valid,
    input  logic            res_stall,
    output iprcs_pkg::res_t res_data,
    input  logic            cfg_wr_en,
    input  logic [10:0]     cfg_wr_data
);

    localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(NUM_PORTS * QUEUE_DEPTH);

    iprcs_pkg::state_t    state_reg;
    iprcs_pkg::state_t    state_next;
    logic [QW-1:0]        rd_ptr_reg   [NUM_PORTS];
    logic [QW-1:0]        wr_ptr_reg   [NUM_PORTS];
    logic [FW-1:0]        fill_reg     [NUM_PORTS];
    logic [31:0]          rx_cnt_reg   [NUM_PORTS];
    logic [31:0]          drop_cnt_reg [NUM_PORTS];
    logic [PW-1:0]        rr_last_reg;
    logic [10:0]          cell_length_reg;
    logic                 res_valid_reg;
    iprcs_pkg::res_t      res_data_reg;
    iprcs_pkg::res_t      res_data_next;
    iprcs_pkg::hdr_t      queue_mem [NUM_PORTS * QUEUE_DEPTH];
    iprcs_pkg::hdr_t      hdr_rd_reg;

    logic                 slot_free;
    logic                 req_accept;
    logic                 is_arrival;
    logic                 port_ok;
    logic [PW-1:0]        arr_port;
    logic                 arr_full;
    logic                 arr_commit;
    logic [31:0]          rx_new;
    logic [31:0]          drop_new;
    logic                 sched_found;
    logic [PW-1:0]        sched_port;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 mem_wr_en;
    logic                 mem_rd_en;
    logic                 res_load;
    iprcs_pkg::seg_ctrl_t seg_ctrl;
    logic                 seg_active;
    iprcs_pkg::res_t      seg_cell;
    iprcs_pkg::hdr_t      arr_hdr;

    assign slot_free  = !res_valid_reg || !res_stall;
    assign req_stall  = (state_reg != iprcs_pkg::ST_IDLE) || !slot_free;
    assign req_accept = req_valid && !req_stall;
    assign is_arrival = (req_data.req_type == iprcs_pkg::REQ_ARRIVAL);
    assign port_ok    = (32'(req_data.port) < NUM_PORTS);
    assign arr_port   = PW'(req_data.port);
    assign arr_full   = (fill_reg[arr_port] == FW'(QUEUE_DEPTH));
    assign arr_commit = req_accept && is_arrival && port_ok;
    assign rx_new     = rx_cnt_reg[arr_port] + 32'd1;
    assign drop_new   = drop_cnt_reg[arr_port] + (arr_full ? 32'd1 : 32'd0);
    assign wr_addr    = AW'(arr_port) * AW'(QUEUE_DEPTH) + AW'(wr_ptr_reg[arr_port]);
    assign rd_addr    = AW'(sched_port) * AW'(QUEUE_DEPTH) + AW'(rd_ptr_reg[sched_port]);

    assign arr_hdr.src  = req_data.src_id;
    assign arr_hdr.dst  = req_data.dst_id;
    assign arr_hdr.prio = req_data.priority_req;
    assign arr_hdr.len  = req_data.pkt_len;

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // round robin search, nearest port after the last one served wins
    always_comb
    begin
        logic [PW:0]   cand_sum;
        logic [PW-1:0] cand;
        sched_found = 1'b0;
        sched_port  = '0;
        for (int k = NUM_PORTS; k >= 1; k--)
        begin
            cand_sum = (PW + 1)'(rr_last_reg) + (PW + 1)'(k);
            cand     = (cand_sum >= (PW + 1)'(NUM_PORTS)) ?
                       PW'(cand_sum - (PW + 1)'(NUM_PORTS)) : PW'(cand_sum);
            if (fill_reg[cand] != '0)
            begin
                sched_found = 1'b1;
                sched_port  = cand;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iprcs_pkg::ST_IDLE:
            begin
                if (req_accept && !is_arrival && sched_found)
                begin
                    state_next = iprcs_pkg::ST_READ;
                end
            end
            iprcs_pkg::ST_READ:
            begin
                state_next = iprcs_pkg::ST_CELL;
            end
            iprcs_pkg::ST_CELL:
            begin
                if (slot_free && seg_cell.last)
                begin
                    state_next = iprcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iprcs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        mem_wr_en     = 1'b0;
        mem_rd_en     = 1'b0;
        seg_ctrl      = '0;
        res_load      = 1'b0;
        res_data_next = '0;
        case (state_reg)
            iprcs_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (is_arrival)
                    begin
                        if (port_ok)
                        begin
                            res_load                 = 1'b1;
                            mem_wr_en                = !arr_full;
                            res_data_next.kind       = arr_full ? iprcs_pkg::KIND_DROP :
                                                                  iprcs_pkg::KIND_ACCEPT;
                            res_data_next.out_port   = req_data.port;
                            res_data_next.rx_total   = rx_new;
                            res_data_next.drop_total = drop_new;
                        end
                    end
                    else if (sched_found)
                    begin
                        mem_rd_en = 1'b1;
                    end
                    else
                    begin
                        res_load           = 1'b1;
                        res_data_next.kind = iprcs_pkg::KIND_IDLE;
                    end
                end
            end
            iprcs_pkg::ST_READ:
            begin
                seg_ctrl.load = 1'b1;
            end
            iprcs_pkg::ST_CELL:
            begin
                if (slot_free)
                begin
                    seg_ctrl.adv  = 1'b1;
                    res_load      = 1'b1;
                    res_data_next = seg_cell;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // queue store
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            queue_mem[wr_addr] <= arr_hdr;
        end
        if (mem_rd_en)
        begin
            hdr_rd_reg <= queue_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= iprcs_pkg::ST_IDLE;
            rr_last_reg     <= PW'(NUM_PORTS - 1);
            cell_length_reg <= iprcs_pkg::CELL_LENGTH_RST;
            res_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                rd_ptr_reg[i]   <= '0;
                wr_ptr_reg[i]   <= '0;
                fill_reg[i]     <= '0;
                rx_cnt_reg[i]   <= '0;
                drop_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cell_length_reg <= cfg_wr_data;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (arr_commit)
            begin
                rx_cnt_reg[arr_port] <= rx_new;
                if (arr_full)
                begin
                    drop_cnt_reg[arr_port] <= drop_new;
                end
                else
                begin
                    fill_reg[arr_port]   <= fill_reg[arr_port] + FW'(1);
                    wr_ptr_reg[arr_port] <= (wr_ptr_reg[arr_port] == QW'(QUEUE_DEPTH - 1)) ?
                                            '0 : wr_ptr_reg[arr_port] + QW'(1);
                end
            end
            if (mem_rd_en)
            begin
                fill_reg[sched_port]   <= fill_reg[sched_port] - FW'(1);
                rd_ptr_reg[sched_port] <= (rd_ptr_reg[sched_port] == QW'(QUEUE_DEPTH - 1)) ?
                                          '0 : rd_ptr_reg[sched_port] + QW'(1);
                rr_last_reg            <= sched_port;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= res_data_next;
        end
    end

    iprcs_seg u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (seg_ctrl),
        .hdr       (hdr_rd_reg),
        .port      (2'(rr_last_reg)),
        .cell_size (cell_length_reg),
        .active    (seg_active),
        .cell_out  (seg_cell)
    );

`ifndef ASSERT_OFF
    a_read_then_cell: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == iprcs_pkg::ST_READ |=> state_reg == iprcs_pkg::ST_CELL)
        else $error("store read not followed by cell output");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        seg_ctrl.load |-> !seg_active)
        else $error("segmenter loaded while busy");

    a_cell_state_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == iprcs_pkg::ST_CELL |-> seg_active)
        else $error("cell state without an active packet");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_ctrl.adv && seg_cell.last) |=> state_reg == iprcs_pkg::ST_IDLE && !seg_active)
        else $error("last cell did not end the schedule");

    a_rr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rr_last_reg) < NUM_PORTS)
        else $error("round robin pointer out of range");
`endif

endmodule

@@ dv/ingress_port_rr_cell_segmenter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// ingress_port_rr_cell_segmenter_unit_tb
// Self-checking bench for the ingress round-robin cell segmenter. A directed
// table covers reset state, field extremes, exact multiples, zero length and
// idle schedules. Random phases follow, one per cell length setting (including
// the minimum, the maximum and values below the minimum), with fill bursts
// that force drops. Every accepted result is checked field by field against a
// local model of the port queues, the round robin and the segmentation.
// ----------------------------------------------------------------------------
module ingress_port_rr_cell_segmenter_unit_tb;

    localparam int NPORT           = iprcs_pkg::NUM_PORTS_DEF;
    localparam int QDEPTH          = iprcs_pkg::QUEUE_DEPTH_DEF;
    localparam int LIMIT_CYCLES    = 2_000_000;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int NUM_PHASES      = 6;

    typedef struct {
        iprcs_pkg::req_t rq;
        bit              typed;
        iprcs_pkg::res_t res;
    } dir_row_t;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    iprcs_pkg::req_t req_data;
    logic            res_valid;
    logic            res_stall;
    iprcs_pkg::res_t res_data;
    logic            cfg_wr_en;
    logic [10:0]     cfg_wr_data;

    // model state
    iprcs_pkg::hdr_t pq_store [NPORT][QDEPTH];
    int              pq_rd    [NPORT];
    int              pq_wr    [NPORT];
    int              pq_fill  [NPORT];
    int              rr_last;
    logic [31:0]     rx_cnt   [NPORT];
    logic [31:0]     drop_cnt [NPORT];
    logic [10:0]     cur_seg_size;

    iprcs_pkg::res_t seg_expect_q[$];
    dir_row_t        dir_tab[$];
    int              fail_cnt;
    int              cycle_cnt;
    int              stall_left;
    bit              send_quiet;
    bit              recv_quiet;

    ingress_port_rr_cell_segmenter_unit #(
        .NUM_PORTS   (NPORT),
        .QUEUE_DEPTH (QDEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic void model_reset();
        for (int p = 0; p < NPORT; p++)
        begin
            pq_rd[p]    = 0;
            pq_wr[p]    = 0;
            pq_fill[p]  = 0;
            rx_cnt[p]   = '0;
            drop_cnt[p] = '0;
        end
        rr_last      = NPORT - 1;
        cur_seg_size = iprcs_pkg::CELL_LENGTH_RST;
    endfunction

    function automatic void segment_predict(input iprcs_pkg::req_t r,
                                            ref iprcs_pkg::res_t outs[$]);
        iprcs_pkg::res_t o;
        iprcs_pkg::hdr_t h;
        int              p;
        int              len;
        int              cl;
        int              seq;
        bit              found;
        logic [8:0]      qid;
        outs.delete();
        o = '0;
        if (r.req_type == iprcs_pkg::REQ_ARRIVAL)
        begin
            p = int'(r.port);
            rx_cnt[p] = rx_cnt[p] + 32'd1;
            if (pq_fill[p] >= QDEPTH)
            begin
                drop_cnt[p] = drop_cnt[p] + 32'd1;
                o.kind = iprcs_pkg::KIND_DROP;
            end
            else
            begin
                h.src = r.src_id;
                h.dst = r.dst_id;
                h.prio = r.priority_req;
                h.len = r.pkt_len;
                pq_store[p][pq_wr[p]] = h;
                pq_wr[p] = (pq_wr[p] + 1) % QDEPTH;
                pq_fill[p]++;
                o.kind = iprcs_pkg::KIND_ACCEPT;
            end
            o.out_port   = r.port;
            o.rx_total   = rx_cnt[p];
            o.drop_total = drop_cnt[p];
            outs.push_back(o);
            return;
        end
        found = 1'b0;
        p = 0;
        for (int k = 1; k <= NPORT; k++)
        begin
            if (!found && pq_fill[(rr_last + k) % NPORT] != 0)
            begin
                p = (rr_last + k) % NPORT;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            o.kind = iprcs_pkg::KIND_IDLE;
            outs.push_back(o);
            return;
        end
        rr_last = p;
        h = pq_store[p][pq_rd[p]];
        pq_rd[p] = (pq_rd[p] + 1) % QDEPTH;
        pq_fill[p]--;
        // lengths below the minimum behave as the minimum
        cl  = (cur_seg_size < iprcs_pkg::MIN_CELL) ? int'(iprcs_pkg::MIN_CELL) :
                                                     int'(cur_seg_size);
        len = int'(h.len);
        qid = {1'b0, h.src} + {1'b0, h.dst};
        seq = 0;
        o.kind         = iprcs_pkg::KIND_CELL;
        o.out_port     = 2'(p);
        o.out_src      = h.src;
        o.out_dst      = h.dst;
        o.out_priority = h.prio;
        o.queue_id     = qid;
        o.flow_id      = {qid, 1'b0};
        while (len > cl)
        begin
            o.cell_bytes = 11'(cl);
            o.cell_seq   = 6'(seq);
            o.last       = 1'b0;
            outs.push_back(o);
            seq++;
            len -= cl;
        end
        o.cell_bytes = 11'(len);
        o.cell_seq   = 6'(seq);
        o.last       = 1'b1;
        outs.push_back(o);
    endfunction

    function automatic iprcs_pkg::req_t mk_arr(logic [1:0] p, logic [7:0] s, logic [7:0] d,
                                               logic [2:0] pr, logic [10:0] len);
        iprcs_pkg::req_t r;
        r.req_type     = iprcs_pkg::REQ_ARRIVAL;
        r.port         = p;
        r.src_id       = s;
        r.dst_id       = d;
        r.priority_req = pr;
        r.pkt_len      = len;
        return r;
    endfunction

    function automatic iprcs_pkg::req_t mk_sched();
        iprcs_pkg::req_t r;
        r = '0;
        r.req_type = iprcs_pkg::REQ_SCHEDULE;
        return r;
    endfunction

    function automatic iprcs_pkg::res_t mk_res(iprcs_pkg::kind_t k, logic [1:0] p,
                                               logic [10:0] nbytes, logic lst,
                                               logic [31:0] rx, logic [31:0] dr);
        iprcs_pkg::res_t o;
        o = '0;
        o.kind       = k;
        o.out_port   = p;
        o.cell_bytes = nbytes;
        o.last       = lst;
        o.rx_total   = rx;
        o.drop_total = dr;
        return o;
    endfunction

    function automatic logic [10:0] rand_len();
        int cl;
        int sel;
        int v;
        cl  = (cur_seg_size < iprcs_pkg::MIN_CELL) ? int'(iprcs_pkg::MIN_CELL) :
                                                     int'(cur_seg_size);
        sel = $urandom_range(0, 99);
        if (sel < 15)
            v = $urandom_range(0, 2047);
        else if (sel < 27)
            v = cl * $urandom_range(1, 2047 / cl);
        else
            v = $urandom_range(0, (3 * cl > 2047) ? 2047 : 3 * cl);
        return 11'(v);
    endfunction

    function automatic iprcs_pkg::req_t rand_req();
        iprcs_pkg::req_t r;
        r.req_type     = ($urandom_range(0, 99) < 45) ? iprcs_pkg::REQ_SCHEDULE :
                                                        iprcs_pkg::REQ_ARRIVAL;
        r.port         = 2'($urandom_range(0, 3));
        r.src_id       = 8'($urandom);
        r.dst_id       = 8'($urandom);
        r.priority_req = 3'($urandom);
        r.pkt_len      = rand_len();
        return r;
    endfunction

    task automatic push_req(iprcs_pkg::req_t r, bit typed, iprcs_pkg::res_t tres);
        iprcs_pkg::res_t outs[$];
        int              gap;
        gap = send_quiet ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        segment_predict(r, outs);
        if (typed)
            outs[0] = tres;
        foreach (outs[i])
            seg_expect_q.push_back(outs[i]);
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (seg_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seg_size(logic [10:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_seg_size = v;
    endtask

    function automatic void check_field(string fname, logic [31:0] e, logic [31:0] a);
        if (a !== e)
        begin
            $error("%s: expected %0h, got %0h", fname, e, a);
            fail_cnt++;
        end
    endfunction

    task automatic check_result(iprcs_pkg::res_t a);
        iprcs_pkg::res_t e;
        if (seg_expect_q.size() == 0)
        begin
            $error("unexpected result, kind %0d", a.kind);
            fail_cnt++;
        end
        else
        begin
            e = seg_expect_q.pop_front();
            check_field("kind", 32'(e.kind), 32'(a.kind));
            check_field("out_port", 32'(e.out_port), 32'(a.out_port));
            check_field("out_src", 32'(e.out_src), 32'(a.out_src));
            check_field("out_dst", 32'(e.out_dst), 32'(a.out_dst));
            check_field("out_priority", 32'(e.out_priority), 32'(a.out_priority));
            check_field("queue_id", 32'(e.queue_id), 32'(a.queue_id));
            check_field("flow_id", 32'(e.flow_id), 32'(a.flow_id));
            check_field("cell_bytes", 32'(e.cell_bytes), 32'(a.cell_bytes));
            check_field("cell_seq", 32'(e.cell_seq), 32'(a.cell_seq));
            check_field("last", 32'(e.last), 32'(a.last));
            check_field("rx_total", e.rx_total, a.rx_total);
            check_field("drop_total", e.drop_total, a.drop_total);
        end
    endtask

    // result side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else
            res_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            check_result(res_data);
            stall_left = recv_quiet ? 0 : $urandom_range(0, 6);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("ingress_port_rr_cell_segmenter_unit_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int              n;
        int              bp;
        iprcs_pkg::req_t r;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        res_stall   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        fail_cnt    = 0;
        cycle_cnt   = 0;
        stall_left  = 0;
        send_quiet  = 1'b0;
        recv_quiet  = 1'b0;
        model_reset();

        // directed table, cell length at its reset value
        dir_tab.push_back('{mk_sched(), 1'b1,
                            mk_res(iprcs_pkg::KIND_IDLE, 2'd0, 11'd0, 1'b0, 32'd0, 32'd0)});
        dir_tab.push_back('{mk_arr(2'd0, 8'h00, 8'h00, 3'd0, 11'd0), 1'b1,
                            mk_res(iprcs_pkg::KIND_ACCEPT, 2'd0, 11'd0, 1'b0, 32'd1, 32'd0)});
        dir_tab.push_back('{mk_arr(2'd3, 8'hff, 8'hff, 3'd7, 11'd2047), 1'b1,
                            mk_res(iprcs_pkg::KIND_ACCEPT, 2'd3, 11'd0, 1'b0, 32'd1, 32'd0)});
        dir_tab.push_back('{mk_arr(2'd1, 8'ha5, 8'h5a, 3'd5, 11'd64), 1'b1,
                            mk_res(iprcs_pkg::KIND_ACCEPT, 2'd1, 11'd0, 1'b0, 32'd1, 32'd0)});
        dir_tab.push_back('{mk_arr(2'd2, 8'h01, 8'hfe, 3'd2, 11'd65), 1'b1,
                            mk_res(iprcs_pkg::KIND_ACCEPT, 2'd2, 11'd0, 1'b0, 32'd1, 32'd0)});
        dir_tab.push_back('{mk_arr(2'd1, 8'h3c, 8'hc3, 3'd1, 11'd128), 1'b1,
                            mk_res(iprcs_pkg::KIND_ACCEPT, 2'd1, 11'd0, 1'b0, 32'd2, 32'd0)});
        // zero length packet on port 0
        dir_tab.push_back('{mk_sched(), 1'b1,
                            mk_res(iprcs_pkg::KIND_CELL, 2'd0, 11'd0, 1'b1, 32'd0, 32'd0)});
        dir_tab.push_back('{mk_sched(), 1'b0, '0});
        dir_tab.push_back('{mk_sched(), 1'b0, '0});
        dir_tab.push_back('{mk_sched(), 1'b0, '0});
        dir_tab.push_back('{mk_sched(), 1'b0, '0});
        dir_tab.push_back('{mk_sched(), 1'b1,
                            mk_res(iprcs_pkg::KIND_IDLE, 2'd0, 11'd0, 1'b0, 32'd0, 32'd0)});
        dir_tab.push_back('{mk_arr(2'd3, 8'h80, 8'h7f, 3'd3, 11'd63), 1'b1,
                            mk_res(iprcs_pkg::KIND_ACCEPT, 2'd3, 11'd0, 1'b0, 32'd2, 32'd0)});
        dir_tab.push_back('{mk_arr(2'd0, 8'h55, 8'haa, 3'd6, 11'd1), 1'b1,
                            mk_res(iprcs_pkg::KIND_ACCEPT, 2'd0, 11'd0, 1'b0, 32'd2, 32'd0)});
        dir_tab.push_back('{mk_sched(), 1'b0, '0});
        dir_tab.push_back('{mk_sched(), 1'b0, '0});
        dir_tab.push_back('{mk_sched(), 1'b1,
                            mk_res(iprcs_pkg::KIND_IDLE, 2'd0, 11'd0, 1'b0, 32'd0, 32'd0)});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            push_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].res);
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: write_seg_size(11'd2047);
                1: write_seg_size(11'd32);
                2: write_seg_size(11'd0);
                3: write_seg_size(11'd31);
                4: write_seg_size(11'($urandom_range(33, 400)));
                default: write_seg_size(11'($urandom_range(401, 2046)));
            endcase
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    // fill one port past its depth to force drops
                    bp = $urandom_range(0, NPORT - 1);
                    repeat (QDEPTH + 2)
                    begin
                        r = rand_req();
                        r.req_type = iprcs_pkg::REQ_ARRIVAL;
                        r.port = 2'(bp);
                        push_req(r, 1'b0, '0);
                    end
                    n += QDEPTH + 2;
                end
                else
                begin
                    push_req(rand_req(), 1'b0, '0);
                    n++;
                end
                if (ph == 2 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("ingress_port_rr_cell_segmenter_unit_tb: PASS");
        else
            $display("ingress_port_rr_cell_segmenter_unit_tb: FAIL");
        $finish;
    end

endmodule
